[hw/rtl/ilf_pkg.sv]
// ----------------------------------------------------------------------------
// ilf_pkg
// types, opcode constants and length decode functions for the
// instruction length fetcher
// ----------------------------------------------------------------------------
package ilf_pkg;

  localparam logic [7:0] PREFIX_CB = 8'hCB;
  localparam logic [7:0] PREFIX_DD = 8'hDD;
  localparam logic [7:0] PREFIX_ED = 8'hED;
  localparam logic [7:0] PREFIX_FD = 8'hFD;

  localparam int unsigned MAX_LEN = 4;

  typedef logic [7:0] byte_t;
  typedef logic [2:0] len_t;

  typedef struct packed {
    logic [15:0] full_opcode;
    byte_t       byte_zero;
    byte_t       byte_one;
    byte_t       byte_two;
    byte_t       byte_three;
    len_t        length;
  } result_t;

  function automatic logic is_prefix(input byte_t b);
    return b inside {PREFIX_CB, PREFIX_DD, PREFIX_ED, PREFIX_FD};
  endfunction

  // length of an unprefixed instruction: 1, 2 or 3
  function automatic len_t plain_length(input byte_t b);
    logic [1:0] x;
    logic [2:0] y;
    logic [2:0] z;
    logic [1:0] p;
    logic       q;
    len_t       len;
    x = b[7:6];
    y = b[5:3];
    z = b[2:0];
    p = b[5:4];
    q = b[3];
    len = 3'd1;
    if (x == 2'd0 && ((z == 3'd0 && y >= 3'd2) || z == 3'd6)) begin
      len = 3'd2;
    end else if (x == 2'd3 && z == 3'd6) begin
      len = 3'd2;
    end else if (x == 2'd0) begin
      if ((z == 3'd1 && !q) || (z == 3'd2 && p >= 2'd2)) begin
        len = 3'd3;
      end
    end else if (x == 2'd3) begin
      if (z == 3'd2 || z == 3'd4 || (z == 3'd3 && y == 3'd0) ||
          (z == 3'd5 && q && p == 2'd0)) begin
        len = 3'd3;
      end
    end
    return len;
  endfunction

  // length of a prefixed instruction: 2, 3 or 4
  function automatic len_t prefixed_length(input byte_t pre, input byte_t op);
    logic ix;
    len_t len;
    ix  = (pre == PREFIX_DD) || (pre == PREFIX_FD);
    len = 3'd2;
    if (ix && (op inside {8'hBE, 8'h7E, 8'h46, 8'h53, 8'h5E, 8'h66, 8'h6E,
                          8'h77, 8'h70})) begin
      len = 3'd3;
    end else if (ix && (op inside {8'hCB, 8'h36, 8'h22, 8'h21, 8'h2A})) begin
      len = 3'd4;
    end else if (pre == PREFIX_ED &&
                 (op inside {8'h43, 8'h53, 8'h73, 8'h4B, 8'h5B, 8'h7B})) begin
      len = 3'd4;
    end
    return len;
  endfunction

endpackage

[hw/rtl/ilf_if.sv]
// ----------------------------------------------------------------------------
// ilf_in_if / ilf_out_if
// valid/ready channels for code bytes and assembled instructions
// ----------------------------------------------------------------------------
interface ilf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;

  modport source (output valid, output code_byte, input ready);
  modport sink   (input valid, input code_byte, output ready);
endinterface

interface ilf_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] full_opcode;
  logic [7:0]  byte_zero;
  logic [7:0]  byte_one;
  logic [7:0]  byte_two;
  logic [7:0]  byte_three;
  logic [2:0]  length;

  modport source (output valid, output full_opcode, output byte_zero,
                  output byte_one, output byte_two, output byte_three,
                  output length, input ready);
  modport sink   (input valid, input full_opcode, input byte_zero,
                  input byte_one, input byte_two, input byte_three,
                  input length, output ready);
endinterface

[hw/rtl/ilf_assembler.sv]
// ----------------------------------------------------------------------------
// ilf_assembler
// holds the bytes of the current instruction and decides its length
// ----------------------------------------------------------------------------
module ilf_assembler (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [7:0]       code_byte,
  output logic             push,
  output ilf_pkg::result_t result
);
  import ilf_pkg::*;

  byte_t held_r   [MAX_LEN];
  byte_t held_nxt [MAX_LEN];
  len_t  taken_r, taken_nxt;
  len_t  exp_r, exp_nxt;
  len_t  taken_eff;
  len_t  taken_new;
  len_t  exp_new;
  logic  done;

  always_comb begin
    // drop a partial instruction if the counters disagree
    if (taken_r > 3'd3 || (exp_r != 3'd0 && taken_r >= exp_r) ||
        (exp_r == 3'd0 && taken_r > 3'd1)) begin
      taken_eff = 3'd0;
    end else begin
      taken_eff = taken_r;
    end

    for (int i = 0; i < MAX_LEN; i++) begin
      held_nxt[i] = held_r[i];
    end

    if (taken_eff == 3'd0) begin
      held_nxt[0] = code_byte;
      held_nxt[1] = '0;
      held_nxt[2] = '0;
      held_nxt[3] = '0;
      taken_new   = 3'd1;
      exp_new     = is_prefix(code_byte) ? 3'd0 : plain_length(code_byte);
    end else if (exp_r == 3'd0) begin
      // second byte of a prefixed opcode
      held_nxt[1] = code_byte;
      taken_new   = 3'd2;
      exp_new     = prefixed_length(held_r[0], code_byte);
    end else begin
      held_nxt[taken_eff[1:0]] = code_byte;
      taken_new = taken_eff + 3'd1;
      exp_new   = exp_r;
    end

    done      = (taken_new == exp_new);
    taken_nxt = done ? 3'd0 : taken_new;
    exp_nxt   = done ? 3'd0 : exp_new;

    push = accept && done;
    result.full_opcode = is_prefix(held_nxt[0]) ? {held_nxt[0], held_nxt[1]}
                                                : {8'h00, held_nxt[0]};
    result.byte_zero   = held_nxt[0];
    result.byte_one    = held_nxt[1];
    result.byte_two    = held_nxt[2];
    result.byte_three  = held_nxt[3];
    result.length      = taken_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taken_r <= '0;
      exp_r   <= '0;
      for (int i = 0; i < MAX_LEN; i++) begin
        held_r[i] <= '0;
      end
    end else if (accept) begin
      taken_r <= taken_nxt;
      exp_r   <= exp_nxt;
      for (int i = 0; i < MAX_LEN; i++) begin
        held_r[i] <= held_nxt[i];
      end
    end
  end

  a_taken_range: assert property (@(posedge clk) disable iff (!rst_n)
    taken_r <= 3'd3) else $error("byte count out of range");

  a_exp_range: assert property (@(posedge clk) disable iff (!rst_n)
    exp_r <= 3'd4 && (exp_r == 3'd0 || taken_r < exp_r))
    else $error("expected length inconsistent with byte count");

  a_clear_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> (taken_r == 3'd0 && exp_r == 3'd0))
    else $error("counters not cleared after instruction");

endmodule

[hw/rtl/ilf_out_stage.sv]
// ----------------------------------------------------------------------------
// ilf_out_stage
// result register with a skid entry so input can flow while output stalls
// ----------------------------------------------------------------------------
module ilf_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  ilf_pkg::result_t push_data,
  output logic             space,
  output logic             out_valid,
  input  logic             out_ready,
  output ilf_pkg::result_t out_data
);
  import ilf_pkg::*;

  result_t main_r, skid_r;
  logic    main_v_r, skid_v_r;
  logic    pop;

  assign pop       = main_v_r && out_ready;
  assign space     = !skid_v_r;
  assign out_valid = main_v_r;
  assign out_data  = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (pop) begin
        main_r   <= skid_r;
        skid_v_r <= 1'b0;
      end
    end else if (push) begin
      if (!main_v_r || pop) begin
        main_r   <= push_data;
        main_v_r <= 1'b1;
      end else begin
        skid_r   <= push_data;
        skid_v_r <= 1'b1;
      end
    end else if (pop) begin
      main_v_r <= 1'b0;
    end
  end

  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> main_v_r) else $error("skid word without main word");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && out_ready) |=> !skid_v_r) else $error("skid word not moved");

  a_length_valid: assert property (@(posedge clk) disable iff (!rst_n)
    main_v_r |-> (main_r.length != 3'd0 && main_r.length <= 3'd4))
    else $error("result length out of range");

endmodule

[hw/rtl/instruction_length_fetcher_top.sv]
// ----------------------------------------------------------------------------
// instruction_length_fetcher_top
// assembles a code byte stream into whole instructions with their length
// ----------------------------------------------------------------------------
// usage:
//   in_word carries one code byte per word, in program order
//   out_word carries one word per completed instruction: the full opcode
//   (prefix in the high byte when prefixed), the four instruction bytes with
//   unused ones zero, and the length 1 to 4
//   a byte is taken on every cycle with in_word.valid and in_word.ready high;
//   the sustained rate is one byte per cycle while the skid entry is free, set
//   by the combinational length decode between the byte-holding registers
//   and the result register; the result word is written into the output
//   register, or the skid entry if the output stalls, as its last byte is taken
//   when the receiver stalls, one result sits in the output register and one
//   more in a skid entry; in_word.ready drops only while the skid entry is full
//   reset (rst_n low, synchronous) empties both result entries and starts a
//   fresh instruction with the next byte
// ----------------------------------------------------------------------------
module instruction_length_fetcher_top (
  input  logic      clk,
  input  logic      rst_n,
  ilf_in_if.sink    in_word,
  ilf_out_if.source out_word
);
  import ilf_pkg::*;

  logic    accept;
  logic    push;
  logic    space;
  result_t asm_result;
  result_t out_data;

  // input flows whenever the skid entry is free, independent of the receiver
  assign in_word.ready = space;
  assign accept        = in_word.valid && space;

  ilf_assembler u_assembler (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .code_byte (in_word.code_byte),
    .push      (push),
    .result    (asm_result)
  );

  ilf_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (asm_result),
    .space     (space),
    .out_valid (out_word.valid),
    .out_ready (out_word.ready),
    .out_data  (out_data)
  );

  // unpack the result word onto the channel
  assign out_word.full_opcode = out_data.full_opcode;
  assign out_word.byte_zero   = out_data.byte_zero;
  assign out_word.byte_one    = out_data.byte_one;
  assign out_word.byte_two    = out_data.byte_two;
  assign out_word.byte_three  = out_data.byte_three;
  assign out_word.length      = out_data.length;

endmodule

[tb/instruction_length_fetcher_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// instruction_length_fetcher_top_tb
// streams code bytes into the length fetcher and checks every assembled
// instruction word against a byte-level decoder kept in the bench, with
// random idling on both channels and one full drain in mid-run
// ----------------------------------------------------------------------------
module instruction_length_fetcher_top_tb;
  import ilf_pkg::*;

  localparam int unsigned RANDOM_BYTES = 1000;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned IDLE_PCT     = 37;
  localparam int unsigned TAIL_CYCLES  = 16;

  // opcodes that sit in the prefixed length lists, used to bias the random stream
  localparam byte_t LISTED_OPS [19] = '{
    8'hBE, 8'h7E, 8'h46, 8'h53, 8'h5E, 8'h66, 8'h6E, 8'h77, 8'h70,
    8'hCB, 8'h36, 8'h22, 8'h21, 8'h2A,
    8'h43, 8'h73, 8'h4B, 8'h5B, 8'h7B
  };

  // a code byte waiting for the driver; hold_for_drain stops the sender until
  // every pending instruction word has come out
  typedef struct {
    byte_t code;
    bit    hold_for_drain;
  } pending_byte_t;

  logic clk;
  logic rst_n;

  logic  in_valid;
  byte_t in_code;
  logic  out_ready;
  logic  in_fire;

  ilf_in_if  in_word ();
  ilf_out_if out_word ();

  assign in_word.valid     = in_valid;
  assign in_word.code_byte = in_code;
  assign out_word.ready    = out_ready;

  instruction_length_fetcher_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .out_word (out_word)
  );

  // stimulus and expectations
  pending_byte_t code_stream_q[$];
  result_t       instr_expect_q[$];

  // decoder state in the bench
  byte_t      instr_bytes [4];
  logic [2:0] taken_cnt;
  logic [2:0] instr_len;    // zero while the length is not yet known

  int unsigned bytes_accepted;
  int unsigned mismatch_cnt;
  int unsigned cycle_cnt;
  logic        calm_stretch;

  // no idling on either side for a window of the random part
  assign calm_stretch = (bytes_accepted >= 400) && (bytes_accepted < 650);

  // clock and reset
  initial begin
    clk = 1'b0;
  end

  always #2 clk = ~clk;

  initial begin
    in_valid  = 1'b0;
    in_code   = '0;
    out_ready = 1'b0;
    in_fire   = 1'b0;
    rst_n     = 1'b0;
  end

  // --------------------------------------------------------------------------
  // bench decoder
  // --------------------------------------------------------------------------

  function automatic bit is_prefix_byte(input byte_t b);
    return b == PREFIX_CB || b == PREFIX_DD || b == PREFIX_ED || b == PREFIX_FD;
  endfunction

  // total length of an unprefixed instruction from its opcode bit pattern
  function automatic logic [2:0] unprefixed_len(input byte_t op);
    casez (op)
      // one immediate byte: relative jumps, ld r,n, alu n, rst-free group
      8'b00??_?110, 8'b11??_?110, 8'b0001_?000, 8'b001?_?000: return 3'd2;
      // immediate word: ld rr,nn, ld (nn) forms, jp/call cc, jp nn, call nn
      8'b00??_0001, 8'b001?_?010, 8'b11??_?010, 8'b11??_?100: return 3'd3;
      8'hC3, 8'hCD: return 3'd3;
      default: return 3'd1;
    endcase
  endfunction

  // total length once the prefix and the second opcode byte are known
  function automatic logic [2:0] prefixed_len(input byte_t pfx, input byte_t op);
    if (pfx == PREFIX_DD || pfx == PREFIX_FD) begin
      // displacement list wins over the four-byte list
      case (op)
        8'hBE, 8'h7E, 8'h46, 8'h53, 8'h5E, 8'h66, 8'h6E, 8'h77, 8'h70: return 3'd3;
        8'hCB, 8'h36, 8'h22, 8'h21, 8'h2A: return 3'd4;
        default: return 3'd2;
      endcase
    end else if (pfx == PREFIX_ED) begin
      case (op)
        8'h43, 8'h53, 8'h73, 8'h4B, 8'h5B, 8'h7B: return 3'd4;
        default: return 3'd2;
      endcase
    end
    return 3'd2;
  endfunction

  task automatic decoder_reset();
    for (int i = 0; i < 4; i++) instr_bytes[i] = '0;
    taken_cnt = '0;
    instr_len = '0;
  endtask

  // one accepted code byte; pushes the instruction word it completes, if any
  task automatic take_code_byte(input byte_t b);
    result_t word;
    // counters out of step: drop the partial instruction
    if (taken_cnt > 3 || (instr_len != 0 && taken_cnt >= instr_len) ||
        (instr_len == 0 && taken_cnt > 1)) begin
      taken_cnt = '0;
    end
    if (taken_cnt == 0) begin
      // new instruction, unused bytes read as zero
      instr_bytes[0] = b;
      instr_bytes[1] = '0;
      instr_bytes[2] = '0;
      instr_bytes[3] = '0;
      taken_cnt      = 3'd1;
      instr_len      = is_prefix_byte(b) ? 3'd0 : unprefixed_len(b);
    end else if (instr_len == 0) begin
      // second opcode byte, a prefix here is only an opcode
      instr_bytes[1] = b;
      taken_cnt      = 3'd2;
      instr_len      = prefixed_len(instr_bytes[0], b);
    end else begin
      instr_bytes[taken_cnt[1:0]] = b;
      taken_cnt = taken_cnt + 3'd1;
    end
    if (instr_len != 0 && taken_cnt == instr_len) begin
      word.full_opcode = is_prefix_byte(instr_bytes[0]) ?
                         {instr_bytes[0], instr_bytes[1]} : {8'h00, instr_bytes[0]};
      word.byte_zero   = instr_bytes[0];
      word.byte_one    = instr_bytes[1];
      word.byte_two    = instr_bytes[2];
      word.byte_three  = instr_bytes[3];
      word.length      = taken_cnt;
      instr_expect_q.push_back(word);
      taken_cnt = '0;
      instr_len = '0;
    end
  endtask

  // --------------------------------------------------------------------------
  // checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [15:0] exp_val,
                                 input logic [15:0] got_val);
    $display("mismatch at cycle %0d: %s expected %h got %h", cycle_cnt, what, exp_val,
             got_val);
    mismatch_cnt++;
  endtask

  task automatic check_instr_word(input result_t got);
    result_t exp_word;
    if (instr_expect_q.size() == 0) begin
      report_mismatch("word with no instruction pending, opcode", 16'h0, got.full_opcode);
    end else begin
      exp_word = instr_expect_q.pop_front();
      if (got.full_opcode !== exp_word.full_opcode)
        report_mismatch("full_opcode", exp_word.full_opcode, got.full_opcode);
      if (got.byte_zero !== exp_word.byte_zero)
        report_mismatch("byte_zero", exp_word.byte_zero, got.byte_zero);
      if (got.byte_one !== exp_word.byte_one)
        report_mismatch("byte_one", exp_word.byte_one, got.byte_one);
      if (got.byte_two !== exp_word.byte_two)
        report_mismatch("byte_two", exp_word.byte_two, got.byte_two);
      if (got.byte_three !== exp_word.byte_three)
        report_mismatch("byte_three", exp_word.byte_three, got.byte_three);
      if (got.length !== exp_word.length)
        report_mismatch("length", exp_word.length, got.length);
    end
  endtask

  // monitor: results first, then the byte taken on the same edge
  always @(posedge clk) begin
    result_t got;
    cycle_cnt <= cycle_cnt + 1;
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      if (out_word.valid === 1'b1 && out_ready) begin
        got.full_opcode = out_word.full_opcode;
        got.byte_zero   = out_word.byte_zero;
        got.byte_one    = out_word.byte_one;
        got.byte_two    = out_word.byte_two;
        got.byte_three  = out_word.byte_three;
        got.length      = out_word.length;
        check_instr_word(got);
      end
      in_fire <= in_valid && (in_word.ready === 1'b1);
      if (in_valid && in_word.ready === 1'b1) begin
        take_code_byte(in_code);
        bytes_accepted <= bytes_accepted + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // driver and receiver, both change on the falling edge
  // --------------------------------------------------------------------------

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (code_stream_q.size() != 0 &&
          !(code_stream_q[0].hold_for_drain && instr_expect_q.size() != 0) &&
          (calm_stretch || $urandom_range(0, 99) >= IDLE_PCT)) begin
        in_valid <= 1'b1;
        in_code  <= code_stream_q[0].code;
        code_stream_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= calm_stretch || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------

  function automatic void push_code(input byte_t b, input bit hold = 1'b0);
    pending_byte_t item;
    item.code           = b;
    item.hold_for_drain = hold;
    code_stream_q.push_back(item);
  endfunction

  // random byte, biased toward prefixes and listed opcodes so that prefixed
  // instructions of every length turn up often
  function automatic byte_t pick_code_byte();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 20) begin
      case ($urandom_range(0, 3))
        0: return PREFIX_CB;
        1: return PREFIX_DD;
        2: return PREFIX_ED;
        default: return PREFIX_FD;
      endcase
    end else if (roll < 40) begin
      return LISTED_OPS[$urandom_range(0, 18)];
    end
    return byte_t'($urandom_range(0, 255));
  endfunction

  initial begin
    decoder_reset();
    bytes_accepted = 0;
    mismatch_cnt   = 0;
    cycle_cnt      = 0;

    // directed part
    push_code(8'h00);                                              // nop, extreme low
    push_code(8'hFF);                                              // rst, extreme high
    push_code(8'h3E); push_code(8'h7F);                            // ld a,n
    push_code(8'h01); push_code(8'h34); push_code(8'h12);          // ld bc,nn
    push_code(8'hC3); push_code(8'h00); push_code(8'h80);          // jp nn
    push_code(PREFIX_DD); push_code(PREFIX_DD);                    // prefix after prefix
    push_code(PREFIX_CB); push_code(8'h7C);                        // bit op
    push_code(PREFIX_ED); push_code(8'h53); push_code(8'h01); push_code(8'hFE);
    push_code(PREFIX_DD); push_code(8'h53); push_code(8'h80);      // same op, index list
    push_code(PREFIX_FD); push_code(8'h36); push_code(8'h7F); push_code(8'h80);
    push_code(PREFIX_ED); push_code(8'hB0);                        // not in any list

    // random part, sender holds once for a full drain halfway through
    for (int unsigned i = 0; i < RANDOM_BYTES; i++) begin
      push_code(pick_code_byte(), i == RANDOM_BYTES / 2);
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (code_stream_q.size() != 0 || in_valid) @(posedge clk);
    while (instr_expect_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog
  always @(posedge clk) begin
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout with %0d instruction words pending", instr_expect_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

endmodule
